### design/sha1_hash_stream_macros.svh
// Assertion macros shared by the SHA-1 stream hasher modules.
`ifndef SHA1_HASH_STREAM_MACROS_SVH
`define SHA1_HASH_STREAM_MACROS_SVH

// Implication checked every clock, off while reset is asserted.
`define SHA1HS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Same, with the consequent checked on the next clock.
`define SHA1HS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sha1hs_pkg.sv
// Types, constants and round functions of the SHA-1 stream hasher.
package sha1hs_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [31:0] IV_E = 32'hC3D2E1F0;

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam int ROUNDS  = 80;
  localparam int ROUND_W = $clog2(ROUNDS);
  localparam int COUNT_W = 61;

  // Fill level where the length field starts, and the last byte of a block.
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;

  localparam int QUEUE_DEPTH = 4;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_INIT_A     = 3'd0;
  localparam logic [2:0] REG_INIT_B     = 3'd1;
  localparam logic [2:0] REG_INIT_C     = 3'd2;
  localparam logic [2:0] REG_INIT_D     = 3'd3;
  localparam logic [2:0] REG_INIT_E     = 3'd4;
  localparam logic [2:0] REG_BYTE_COUNT = 3'd5;

  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic [4:0][31:0]     words;
    logic [COUNT_W-1:0]   count;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_ZERO,
    ST_LEN,
    ST_OUT
  } back_state_e;

  function automatic logic [31:0] round_f(logic [ROUND_W-1:0] r, logic [31:0] b,
                                          logic [31:0] c, logic [31:0] d);
    logic [31:0] f;
    if (r < ROUND_W'(20)) begin
      f = (b & c) | (~b & d);
    end else if (r < ROUND_W'(40)) begin
      f = b ^ c ^ d;
    end else if (r < ROUND_W'(60)) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic logic [31:0] round_k(logic [ROUND_W-1:0] r);
    logic [31:0] k;
    if (r < ROUND_W'(20)) begin
      k = K_0;
    end else if (r < ROUND_W'(40)) begin
      k = K_1;
    end else if (r < ROUND_W'(60)) begin
      k = K_2;
    end else begin
      k = K_3;
    end
    return k;
  endfunction

endpackage

### design/sha1hs_front.sv
// Input side: takes stream words and queues them for the hashing engine.
`include "sha1_hash_stream_macros.svh"

module sha1hs_front #(
  parameter int Depth = sha1hs_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic [7:0]         s_data_i,
  input  logic               s_has_byte_i,
  input  logic               s_last_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output sha1hs_pkg::item_t  q_item_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  sha1hs_pkg::item_t       mem_q [Depth];
  logic [AW-1:0]           wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]           cnt_q;
  logic                    push, pop;
  sha1hs_pkg::item_t       item_in;

  assign item_in.data     = s_data_i;
  assign item_in.has_byte = s_has_byte_i;
  assign item_in.is_last  = s_last_i;

  assign s_ready_o = (cnt_q != CW'(Depth));
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_ptr_q];
  assign push      = s_valid_i && s_ready_o;
  assign pop       = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `SHA1HS_ASSERT_NXT(a_front_fill, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue count did not grow on push")

endmodule

### design/sha1hs_back.sv
// Hashing engine: packs bytes into words, runs the 80 rounds, pads, emits the digest.
`include "sha1_hash_stream_macros.svh"

module sha1hs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha1hs_pkg::cfg_t   cfg_i,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  sha1hs_pkg::item_t  q_item_i,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output logic [31:0]        m_word_o,
  output logic [2:0]         m_index_o,
  output logic               m_last_o
);

  localparam int RW = sha1hs_pkg::ROUND_W;

  sha1hs_pkg::back_state_e state_q, state_d, ret_q, ret_d;

  logic [RW-1:0]                    round_q;
  logic [5:0]                       fill_q, fill_d;
  logic [sha1hs_pkg::COUNT_W-1:0]   total_q, total_d;
  logic                             open_q, open_d;
  logic [23:0]                      acc_q;
  logic [15:0][31:0]                w_q;
  logic [4:0][31:0]                 wv_q;
  logic [4:0][31:0]                 chain_q;
  logic [2:0]                       widx_q, widx_d;
  logic                             out_vld_q;
  logic [31:0]                      out_word_q;
  logic [2:0]                       out_idx_q;
  logic                             out_last_q;

  logic        push_en;
  logic [7:0]  push_byte;
  logic        w_shift;
  logic [31:0] w_in;
  logic        load_cfg;
  logic        out_load;
  logic [31:0] sched_new;
  logic [31:0] t_sum;
  logic [63:0] bit_len;
  logic [7:0]  len_byte;

  assign bit_len   = {total_q, 3'b000};
  assign len_byte  = bit_len[8 * (7 - fill_q[2:0]) +: 8];
  assign sched_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign t_sum     = {wv_q[0][26:0], wv_q[0][31:27]}
                   + sha1hs_pkg::round_f(round_q, wv_q[1], wv_q[2], wv_q[3])
                   + wv_q[4] + sha1hs_pkg::round_k(round_q) + w_q[0];

  assign q_ready_o = (state_q == sha1hs_pkg::ST_IDLE);
  assign m_valid_o = out_vld_q;
  assign m_word_o  = out_word_q;
  assign m_index_o = out_idx_q;
  assign m_last_o  = out_last_q;

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    fill_d    = fill_q;
    total_d   = total_q;
    open_d    = open_q;
    widx_d    = widx_q;
    push_en   = 1'b0;
    push_byte = 8'h00;
    load_cfg  = 1'b0;
    out_load  = 1'b0;

    case (state_q)
      sha1hs_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          open_d   = 1'b1;
          load_cfg = !open_q;
          total_d  = open_q ? total_q : cfg_i.count;
          if (q_item_i.has_byte) begin
            push_en   = 1'b1;
            push_byte = q_item_i.data;
            total_d   = total_d + 1'b1;
          end
          if (q_item_i.has_byte && fill_q == sha1hs_pkg::FILL_LAST) begin
            state_d = sha1hs_pkg::ST_ROUND;
            ret_d   = q_item_i.is_last ? sha1hs_pkg::ST_PAD : sha1hs_pkg::ST_IDLE;
          end else if (q_item_i.is_last) begin
            state_d = sha1hs_pkg::ST_PAD;
          end
        end
      end
      sha1hs_pkg::ST_ROUND: begin
        if (round_q == RW'(sha1hs_pkg::ROUNDS - 1)) begin
          state_d = sha1hs_pkg::ST_ADD;
        end
      end
      sha1hs_pkg::ST_ADD: begin
        state_d = ret_q;
      end
      sha1hs_pkg::ST_PAD: begin
        push_en   = 1'b1;
        push_byte = sha1hs_pkg::PAD_BYTE;
        state_d   = sha1hs_pkg::ST_ZERO;
        if (fill_q == sha1hs_pkg::FILL_LAST) begin
          state_d = sha1hs_pkg::ST_ROUND;
          ret_d   = sha1hs_pkg::ST_ZERO;
        end
      end
      sha1hs_pkg::ST_ZERO: begin
        if (fill_q == sha1hs_pkg::LEN_START) begin
          state_d = sha1hs_pkg::ST_LEN;
        end else begin
          push_en = 1'b1;
          if (fill_q == sha1hs_pkg::FILL_LAST) begin
            state_d = sha1hs_pkg::ST_ROUND;
            ret_d   = sha1hs_pkg::ST_ZERO;
          end
        end
      end
      sha1hs_pkg::ST_LEN: begin
        push_en   = 1'b1;
        push_byte = len_byte;
        if (fill_q == sha1hs_pkg::FILL_LAST) begin
          state_d = sha1hs_pkg::ST_ROUND;
          ret_d   = sha1hs_pkg::ST_OUT;
        end
      end
      sha1hs_pkg::ST_OUT: begin
        if (!out_vld_q || m_ready_i) begin
          out_load = 1'b1;
          widx_d   = widx_q + 1'b1;
          if (widx_q == sha1hs_pkg::LAST_WORD_IDX) begin
            widx_d  = '0;
            open_d  = 1'b0;
            state_d = sha1hs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = sha1hs_pkg::ST_IDLE;
      end
    endcase

    if (push_en) begin
      fill_d = fill_q + 1'b1;
    end

    // The schedule line shifts on every completed word and on every round.
    w_shift = (push_en && fill_q[1:0] == 2'b11) || (state_q == sha1hs_pkg::ST_ROUND);
    w_in    = (state_q == sha1hs_pkg::ST_ROUND) ? {sched_new[30:0], sched_new[31]}
                                                : {acc_q, push_byte};
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      acc_q <= {acc_q[15:0], push_byte};
    end
    if (w_shift) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= w_in;
    end
    if (load_cfg) begin
      chain_q <= cfg_i.words;
    end else if (state_q == sha1hs_pkg::ST_ADD) begin
      for (int i = 0; i < 5; i++) begin
        chain_q[i] <= chain_q[i] + wv_q[i];
      end
    end
    if (state_q != sha1hs_pkg::ST_ROUND && state_d == sha1hs_pkg::ST_ROUND) begin
      wv_q <= chain_q;
    end else if (state_q == sha1hs_pkg::ST_ROUND) begin
      wv_q[0] <= t_sum;
      wv_q[1] <= wv_q[0];
      wv_q[2] <= {wv_q[1][1:0], wv_q[1][31:2]};
      wv_q[3] <= wv_q[2];
      wv_q[4] <= wv_q[3];
    end
    total_q <= total_d;
    if (out_load) begin
      out_word_q <= chain_q[widx_q];
      out_idx_q  <= widx_q;
      out_last_q <= (widx_q == sha1hs_pkg::LAST_WORD_IDX);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sha1hs_pkg::ST_IDLE;
      ret_q     <= sha1hs_pkg::ST_IDLE;
      round_q   <= '0;
      fill_q    <= '0;
      open_q    <= 1'b0;
      widx_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      open_q  <= open_d;
      widx_q  <= widx_d;
      if (state_q == sha1hs_pkg::ST_ROUND) begin
        round_q <= round_q + 1'b1;
      end else begin
        round_q <= '0;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  `SHA1HS_ASSERT_IMP(a_round_on_full, state_q != sha1hs_pkg::ST_ROUND && state_d == sha1hs_pkg::ST_ROUND, fill_d == '0, "compression started on a partial block")
  `SHA1HS_ASSERT_IMP(a_len_position, state_q == sha1hs_pkg::ST_LEN, fill_q[5:3] == 3'b111, "length bytes outside the last eight slots")
  `SHA1HS_ASSERT_IMP(a_out_aligned, state_q == sha1hs_pkg::ST_OUT, fill_q == '0 && open_q, "digest read-out with a partial block")
  `SHA1HS_ASSERT_NXT(a_msg_close, out_load && widx_q == sha1hs_pkg::LAST_WORD_IDX, state_q == sha1hs_pkg::ST_IDLE && !open_q && out_last_q, "message not closed after the fifth word")

endmodule

### design/sha1_hash_stream.sv
// SHA-1 stream hasher: top level with configuration registers, input queue and engine.
//
// Usage:
//  - Input stream (s_axis_*): one word per message byte. tdata[7:0] is the byte,
//    tuser is 1 when tdata carries a byte (0 for an empty word), tlast ends the
//    message. An empty word with tlast closes a message without adding a byte.
//  - Output stream (m_axis_*): after each tlast the five digest words H0..H4
//    come out in order; tuser gives the word index 0..4, tlast marks word 4.
//  - Config port (APB, 64-bit data, 8-byte register spacing): words A..E of the
//    starting chaining value at 0x00..0x20 and the starting byte count at 0x28.
//    They are loaded when a message opens; writes take effect at the next one.
//  - Throughput: the engine takes bytes while idle and takes none while it runs the
//    80 rounds and the final add of each full 64-byte block.
//    A small input queue keeps taking words while the engine is in its round loop.
//  - Latency from tlast to the first digest word: the padding and length bytes, one
//    or two compressions, and the queue and output register; the digest words then
//    follow in order.
//  - Reset restores the standard SHA-1 starting values and a zero byte count and
//    empties the queue. A stalled receiver holds the digest word in the output
//    register and the engine waits before loading the next one.
module sha1_hash_stream #(
  parameter int QueueDepth = sha1hs_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,   // is_last
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast,   // last_word
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  sha1hs_pkg::cfg_t   cfg_q;
  logic               cfg_wr;
  logic [2:0]         reg_idx;
  logic               q_valid, q_ready;
  sha1hs_pkg::item_t  q_item;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers; an address past the byte count is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.words[0] <= sha1hs_pkg::IV_A;
      cfg_q.words[1] <= sha1hs_pkg::IV_B;
      cfg_q.words[2] <= sha1hs_pkg::IV_C;
      cfg_q.words[3] <= sha1hs_pkg::IV_D;
      cfg_q.words[4] <= sha1hs_pkg::IV_E;
      cfg_q.count    <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        sha1hs_pkg::REG_INIT_A:     cfg_q.words[0] <= pwdata[31:0];
        sha1hs_pkg::REG_INIT_B:     cfg_q.words[1] <= pwdata[31:0];
        sha1hs_pkg::REG_INIT_C:     cfg_q.words[2] <= pwdata[31:0];
        sha1hs_pkg::REG_INIT_D:     cfg_q.words[3] <= pwdata[31:0];
        sha1hs_pkg::REG_INIT_E:     cfg_q.words[4] <= pwdata[31:0];
        sha1hs_pkg::REG_BYTE_COUNT: cfg_q.count    <= pwdata[sha1hs_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sha1hs_pkg::REG_INIT_A:     prdata = {32'h0, cfg_q.words[0]};
      sha1hs_pkg::REG_INIT_B:     prdata = {32'h0, cfg_q.words[1]};
      sha1hs_pkg::REG_INIT_C:     prdata = {32'h0, cfg_q.words[2]};
      sha1hs_pkg::REG_INIT_D:     prdata = {32'h0, cfg_q.words[3]};
      sha1hs_pkg::REG_INIT_E:     prdata = {32'h0, cfg_q.words[4]};
      sha1hs_pkg::REG_BYTE_COUNT: prdata = {3'b000, cfg_q.count};
      default:                    prdata = '0;
    endcase
  end

  // Front: input queue.
  sha1hs_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_has_byte_i (s_axis_tuser),
    .s_last_i     (s_axis_tlast),
    .q_valid_o    (q_valid),
    .q_ready_i    (q_ready),
    .q_item_o     (q_item)
  );

  // Back: packing, compression, padding and digest read-out.
  sha1hs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_item_i  (q_item),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_word_o  (m_axis_tdata),
    .m_index_o (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

endmodule

### tb/sha1_hash_stream_test.sv
// Self-checking testbench for the SHA-1 stream hasher: directed table, then random messages.
//
// The input stream carries one word per message byte. Every accepted word is fed to a
// software SHA-1 predictor kept in this module, which tracks the same chaining words,
// block buffer, byte count and fill level as the block. Each word with tlast produces five
// expected digest words, queued in order. The output monitor pops one per accepted output
// word and compares data, index and last flag.
//
// Run layout:
//   - directed table at reset configuration (empty message, "abc", empty steps, extremes)
//   - three random phases, each starting with a fresh register setting written over APB
//     while the hasher is idle: random values with junk in the upper bits, all-zero words
//     with the byte count at its maximum (bit length wraps), all-one words with a zero count
//   - each phase opens with one padding-boundary message (55, 56 or 64 bytes)
//   - idling: sender 6% / receiver 83%, then the reverse, then none
// A watchdog ends the run if nothing is accepted anywhere for too long.
module sha1_hash_stream_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sha1hs_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 12;
  // Worst quiet stretch: padding, two compressions and long stalls at 83%.
  localparam int STALL_LIMIT   = 4000;
  // Cycles allowed for the engine to go idle before a register write or the end.
  localparam int SETTLE_CYCLES = 300;
  // Words with a byte or tlast per phase, boundary message included.
  localparam int PHASE_ITEMS   = 58;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  // Index past the last register: a write there must change nothing.
  localparam logic [2:0] REG_SPARE = 3'd6;

  // Well-known digests at the standard starting values.
  localparam logic [159:0] SHA1_EMPTY = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
  localparam logic [159:0] SHA1_ABC   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  pos;
    logic        last;
  } digest_word_t;

  typedef struct {
    logic [7:0]   data;
    logic         has_byte;
    logic         is_last;
    bit           known;      // digest typed in below
    logic [159:0] digest;
  } stim_row_t;

  // Directed stimulus. Rows with a typed digest are checked against it; the rest go
  // through the predictor.
  stim_row_t dir_rows [17] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, SHA1_EMPTY},   // empty message right after reset
    '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, SHA1_ABC},     // "abc", tlast on the last byte
    '{8'hA5, 1'b0, 1'b0, 1'b0, 160'h0},       // empty step opens a message, data ignored
    '{8'hFF, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h5A, 1'b0, 1'b1, 1'b0, 160'h0},       // closed by an empty word with tlast
    '{8'hFF, 1'b1, 1'b1, 1'b0, 160'h0},       // one-byte messages at the extremes
    '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},
    '{8'hC3, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'h3C, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'hFF, 1'b0, 1'b1, 1'b1, SHA1_EMPTY},   // empty message after empty steps
    '{8'h80, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h7F, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h01, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'hFE, 1'b1, 1'b1, 1'b0, 160'h0}
  };

  // Padding boundaries: pad fits exactly, pad spills into an extra block, full block first.
  int boundary_len [3] = '{55, 56, 64};

  // DUT ports; the inputs are driven from time zero.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
  logic        s_axis_tuser  = 1'b0;    // [0] has_byte
  logic        s_axis_tlast  = 1'b0;    // is_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;            // [31:0] digest_word
  logic [2:0]  m_axis_tuser;            // [2:0] word_index
  logic        m_axis_tlast;            // last_word
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [5:0]  paddr         = 6'd0;
  logic [63:0] pwdata        = 64'd0;
  logic [63:0] prdata;
  logic        pready;

  // Idle percentages for both sides, set per phase.
  int send_idle = 0;
  int recv_idle = 0;
  int mismatches = 0;
  int msg_items = 0;          // accepted words that carry a byte or end a message
  int quiet_cycles = 0;

  digest_word_t digest_q [$];

  // Predictor state: register copies and the running hash.
  logic [31:0]        start_words [5];
  logic [COUNT_W-1:0] start_count;
  logic [31:0]        chain [5];
  logic [7:0]         block_buf [64];
  logic [COUNT_W-1:0] byte_total;
  int                 fill;
  bit                 msg_open;

  sha1_hash_stream u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  function automatic logic [31:0] rol32(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // One 80-round compression of block_buf into chain.
  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++) begin
      w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int r = 0; r < ROUNDS; r++) begin
      // message schedule kept as a 16-word ring
      if (r >= 16) begin
        w[r%16] = rol32(w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16], 1);
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_2;
      end else begin
        f = b ^ c ^ d;
        k = K_3;
      end
      t = rol32(a, 5) + f + e + k + w[r%16];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endfunction

  // Absorb one accepted word; returns 1 with the digest when the word ends a message.
  function automatic bit absorb_word(input item_t it, output logic [4:0][31:0] dig);
    logic [63:0] bit_len;
    // the first word of a message picks up the registers
    if (!msg_open) begin
      for (int i = 0; i < 5; i++) chain[i] = start_words[i];
      byte_total = start_count;
      fill = 0;
      msg_open = 1'b1;
    end
    if (it.has_byte) begin
      block_buf[fill] = it.data;
      fill = (fill + 1) % 64;
      byte_total = byte_total + 1'b1;   // wraps at 2^61
      if (fill == 0) compress_block();
    end
    dig = '0;
    if (!it.is_last) return 1'b0;
    // padding: marker byte, zeros, 64-bit bit length; maybe one extra block
    block_buf[fill] = PAD_BYTE;
    fill++;
    if (fill > LEN_START) begin
      for (int i = fill; i < 64; i++) block_buf[i] = 8'h00;
      compress_block();
      fill = 0;
    end
    for (int i = fill; i < LEN_START; i++) block_buf[i] = 8'h00;
    bit_len = {byte_total, 3'b000};
    for (int i = 0; i < 8; i++) block_buf[LEN_START+i] = bit_len[63-8*i -: 8];
    compress_block();
    for (int i = 0; i < 5; i++) dig[i] = chain[i];
    fill = 0;
    msg_open = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch @%0t: %s got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Send one word; on acceptance run the predictor and queue any digest.
  // Called right after a rising edge.
  task automatic send_word(item_t it, bit has_known, logic [159:0] known_dig);
    logic [4:0][31:0] dig;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it.data;
    s_axis_tuser  <= it.has_byte;
    s_axis_tlast  <= it.is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (it.has_byte || it.is_last) msg_items++;
    if (absorb_word(it, dig)) begin
      for (int i = 0; i < 5; i++) begin
        if (has_known) dig[i] = known_dig[159-32*i -: 32];
        digest_q.push_back('{word: dig[i], pos: 3'(i), last: (3'(i) == LAST_WORD_IDX)});
      end
    end
  endtask

  // Hold the input until every queued digest word has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (digest_q.size() != 0);
  endtask

  // APB write: setup, then access until pready. psel stays up when more writes follow.
  task automatic write_reg(logic [2:0] idx, logic [63:0] value, bit more);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx < REG_BYTE_COUNT) begin
      start_words[idx] = value[31:0];
    end else if (idx == REG_BYTE_COUNT) begin
      start_count = value[COUNT_W-1:0];
    end
    if (!more) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
  endtask

  // Register setting per phase; only called with the hasher idle.
  task automatic program_regs(int phase);
    logic [63:0] word_val;
    logic [63:0] count_val;
    for (int i = REG_INIT_A; i <= REG_INIT_E; i++) begin
      case (phase)
        0:       word_val = {$urandom, $urandom};     // upper half must be ignored
        1:       word_val = 64'h0;
        default: word_val = {64{1'b1}};
      endcase
      write_reg(3'(i), word_val, 1'b1);
    end
    case (phase)
      0:       count_val = {$urandom, $urandom};
      1:       count_val = 64'(COUNT_MAX);           // bit length wraps on the first byte
      default: count_val = 64'hE000_0000_0000_0000;  // only bits above the count: zero
    endcase
    write_reg(REG_BYTE_COUNT, count_val, 1'b1);
    write_reg(REG_SPARE, {$urandom, $urandom}, 1'b0);
  endtask

  // Random message of len bytes, with the odd empty step mixed in. Ends either on the
  // last byte or on a separate empty word with tlast.
  task automatic send_message(int len);
    item_t it;
    bit    close_empty;
    close_empty = (len == 0) || ($urandom_range(1) == 1);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(15) == 0) begin
        it = '{data: 8'($urandom), has_byte: 1'b0, is_last: 1'b0};
        send_word(it, 1'b0, 160'h0);
      end
      it = '{data: 8'($urandom), has_byte: 1'b1, is_last: (n == len - 1) && !close_empty};
      send_word(it, 1'b0, 160'h0);
    end
    if (close_empty) begin
      it = '{data: 8'($urandom), has_byte: 1'b0, is_last: 1'b1};
      send_word(it, 1'b0, 160'h0);
    end
  endtask

  // Output side: random stalls, and every accepted word checked against the queue.
  always @(posedge clk_i) begin : digest_check
    digest_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("digest word with nothing pending", m_axis_tdata, 32'h0);
      end else begin
        want = digest_q.pop_front();
        if (m_axis_tdata !== want.word) begin
          report_mismatch("digest_word", m_axis_tdata, want.word);
        end
        if (m_axis_tuser !== want.pos) begin
          report_mismatch("word_index", 32'(m_axis_tuser), 32'(want.pos));
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch("last_word", 32'(m_axis_tlast), 32'(want.last));
        end
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle);
  end

  // Watchdog: too long without any accepted word or register access ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    item_t it;
    int    phase_end;
    int    len;
    // predictor at reset: standard starting values, zero count, no message open
    start_words = '{IV_A, IV_B, IV_C, IV_D, IV_E};
    start_count = '0;
    fill        = 0;
    msg_open    = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle = 6;  recv_idle = 83; end
        1:       begin send_idle = 83; recv_idle = 6;  end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase

      if (phase == 0) begin
        for (int i = 0; i < $size(dir_rows); i++) begin
          it = '{data: dir_rows[i].data, has_byte: dir_rows[i].has_byte,
                 is_last: dir_rows[i].is_last};
          send_word(it, dir_rows[i].known, dir_rows[i].digest);
        end
      end

      // registers change only once the engine has gone quiet
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      program_regs(phase);
      @(posedge clk_i);

      phase_end = msg_items + PHASE_ITEMS;
      send_message(boundary_len[phase]);
      while (msg_items < phase_end) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 70) : $urandom_range(0, 12);
        send_message(len);
        // hold off now and then until the digest has fully drained
        if ($urandom_range(5) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
